/* sv/serial_line_editor_defines.svh */
// assertion macros for the serial line editor
// used by the top level; expects clk and rst_n in scope
`ifndef SERIAL_LINE_EDITOR_DEFINES_SVH
`define SERIAL_LINE_EDITOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/sle_pkg.sv */
// shared types and constants of the serial line editor
// no dependencies
package sle_pkg;

    localparam int LINE_CAP   = 32;
    localparam int LEN_W      = $clog2(LINE_CAP);
    localparam int FIFO_DEPTH = 2;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAP - 1);

    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;
    localparam logic [7:0] CH_DEL      = 8'h7F;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;
    localparam logic [1:0] KIND_RSVD = 2'd3;

    typedef enum logic [1:0] {
        OP_PRINT,
        OP_ERASE,
        OP_EOL
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
    } cmd_t;

endpackage

/* sv/sle_ram.sv */
// generic single-write, single-read memory with registered read data
// no dependencies
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/sle_front.sv */
// front end: accepts received bytes and sorts them into line commands
// depends on sle_pkg
module sle_front (
    input  logic          rx_valid,
    output logic          rx_ready,
    input  logic [7:0]    rx_byte,
    input  logic          q_full,
    output logic          q_push,
    output sle_pkg::cmd_t q_cmd
);

    logic keep;

    always_comb
    begin
        keep        = 1'b1;
        q_cmd.data  = rx_byte;
        q_cmd.op    = sle_pkg::OP_PRINT;
        priority if (rx_byte == sle_pkg::CH_CR || rx_byte == sle_pkg::CH_LF)
        begin
            q_cmd.op = sle_pkg::OP_EOL;
        end
        else if (rx_byte == sle_pkg::CH_BS || rx_byte == sle_pkg::CH_DEL)
        begin
            q_cmd.op = sle_pkg::OP_ERASE;
        end
        else if (rx_byte >= sle_pkg::CH_PRINT_LO && rx_byte <= sle_pkg::CH_PRINT_HI)
        begin
            q_cmd.op = sle_pkg::OP_PRINT;
        end
        else
        begin
            keep = 1'b0;
        end
    end

    // ignored bytes (other controls and 80..FF) are taken and dropped
    assign rx_ready = !q_full;
    assign q_push   = rx_valid && !q_full && keep;

endmodule

/* sv/sle_cmd_fifo.sv */
// short command queue between front end and back end
// depends on sle_pkg
module sle_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sle_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output sle_pkg::cmd_t head
);

    localparam int PTR_W = (sle_pkg::FIFO_DEPTH > 1) ? $clog2(sle_pkg::FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(sle_pkg::FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(sle_pkg::FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(sle_pkg::FIFO_DEPTH);

    sle_pkg::cmd_t    entry_reg [sle_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* sv/sle_back.sv */
// back end: line store, edit sequencer and output register
// depends on sle_pkg and sle_ram
module sle_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  sle_pkg::cmd_t q_head,
    output logic          q_pop,
    output logic          res_valid,
    input  logic          res_ready,
    output logic [7:0]    out_byte,
    output logic [1:0]    out_kind,
    output logic          last_of_run
);

    localparam int LW = sle_pkg::LEN_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERASE,
        ST_CR,
        ST_LF,
        ST_TRIM,
        ST_DRAIN,
        ST_END
    } state_t;

    state_t        state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [1:0]    step_reg, step_next;
    logic          valid_reg, valid_next;
    logic [7:0]    byte_reg, byte_next;
    logic [1:0]    kind_reg, kind_next;
    logic          last_reg, last_next;

    logic          can_load;
    logic          emit;
    logic [7:0]    e_byte;
    logic [1:0]    e_kind;
    logic          e_last;
    logic          wr_en;
    logic [LW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [LW-1:0] idx_inc;

    sle_ram #(
        .WIDTH (8),
        .DEPTH (sle_pkg::LINE_CAP)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (len_reg),
        .wr_data (q_head.data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign can_load = !valid_reg || res_ready;
    assign idx_inc  = idx_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        e_byte     = 8'h00;
        e_kind     = sle_pkg::KIND_ECHO;
        e_last     = 1'b0;
        wr_en      = 1'b0;
        rd_addr    = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && can_load)
                begin
                    q_pop = 1'b1;
                    unique case (q_head.op)
                        sle_pkg::OP_PRINT:
                        begin
                            if (len_reg != sle_pkg::LEN_MAX)
                            begin
                                wr_en    = 1'b1;
                                len_next = len_reg + 1'b1;
                                emit     = 1'b1;
                                e_byte   = q_head.data;
                                e_last   = 1'b1;
                            end
                        end
                        sle_pkg::OP_ERASE:
                        begin
                            if (len_reg != '0)
                            begin
                                len_next   = len_reg - 1'b1;
                                step_next  = 2'd0;
                                state_next = ST_ERASE;
                            end
                        end
                        sle_pkg::OP_EOL:
                        begin
                            if (len_reg != '0)
                            begin
                                state_next = ST_CR;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ERASE:
            begin
                if (can_load)
                begin
                    emit      = 1'b1;
                    e_byte    = (step_reg == 2'd1) ? sle_pkg::CH_SPACE : sle_pkg::CH_BS;
                    e_last    = (step_reg == 2'd2);
                    step_next = step_reg + 1'b1;
                    if (step_reg == 2'd2)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CR:
            begin
                if (can_load)
                begin
                    emit       = 1'b1;
                    e_byte     = sle_pkg::CH_CR;
                    state_next = ST_LF;
                end
            end
            ST_LF:
            begin
                // fetch the last held byte for the trim check
                rd_addr = len_reg - 1'b1;
                if (can_load)
                begin
                    emit       = 1'b1;
                    e_byte     = sle_pkg::CH_LF;
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                if (rd_data == sle_pkg::CH_SPACE)
                begin
                    len_next = len_reg - 1'b1;
                    rd_addr  = len_reg - LW'(2);
                    if (len_reg == LW'(1))
                    begin
                        state_next = ST_END;
                    end
                end
                else
                begin
                    idx_next   = '0;
                    rd_addr    = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (can_load)
                begin
                    emit     = 1'b1;
                    e_byte   = rd_data;
                    e_kind   = sle_pkg::KIND_LINE;
                    idx_next = idx_inc;
                    rd_addr  = idx_inc;
                    if (idx_inc == len_reg)
                    begin
                        state_next = ST_END;
                    end
                end
            end
            ST_END:
            begin
                if (can_load)
                begin
                    emit       = 1'b1;
                    e_byte     = 8'h00;
                    e_kind     = sle_pkg::KIND_END;
                    e_last     = 1'b1;
                    len_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        valid_next = valid_reg;
        byte_next  = byte_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            byte_next  = e_byte;
            kind_next  = e_kind;
            last_next  = e_last;
        end
        else if (res_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
            valid_reg <= 1'b0;
            byte_reg  <= '0;
            kind_reg  <= sle_pkg::KIND_ECHO;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
            byte_reg  <= byte_next;
            kind_reg  <= kind_next;
            last_reg  <= last_next;
        end
    end

    assign res_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign out_kind    = kind_reg;
    assign last_of_run = last_reg;

endmodule

/* sv/serial_line_editor.sv */
// a printable echo beat is loaded into the output register as its command is popped
// back end steps: printable (pop, echo unless the line is full), erase (pop, three echo beats), ignored bytes none
// end of a nonempty line, n held and t trailing spaces: pop, cr, lf, t + 1 trim checks,
//   n - t drain beats, end marker; t trim checks and no drain beats when the line is all spaces
// the output register sends at most one result per cycle; a two-entry queue decouples rx
// reset clears line length, queue and output valid; the line store itself is not cleared
`include "serial_line_editor_defines.svh"

module serial_line_editor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [7:0] out_byte,
    output logic [1:0] out_kind,
    output logic       last_of_run
);

    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_not_empty;
    sle_pkg::cmd_t q_cmd;
    sle_pkg::cmd_t q_head;

    sle_front u_front (
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    sle_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    sle_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .out_byte    (out_byte),
        .out_kind    (out_kind),
        .last_of_run (last_of_run)
    );

    `SLE_ASSERT_NOW(a_kind_legal, res_valid, out_kind != sle_pkg::KIND_RSVD, "reserved kind")
    `SLE_ASSERT_NOW(a_end_marker, res_valid && out_kind == sle_pkg::KIND_END, out_byte == 8'h00 && last_of_run, "bad end marker")
    `SLE_ASSERT_NOW(a_line_byte, res_valid && out_kind == sle_pkg::KIND_LINE, !last_of_run && out_byte >= sle_pkg::CH_PRINT_LO && out_byte <= sle_pkg::CH_PRINT_HI, "bad line byte")
    `SLE_ASSERT_NEXT(a_line_then_more, res_valid && res_ready && out_kind == sle_pkg::KIND_LINE, res_valid, "line beat not followed by another beat")

endmodule

/* bench/line_echo_checker.sv */
// checker for the serial line editor: watches the rx and result channels,
// predicts echo, line and end beats, and counts mismatches
// depends on sle_pkg
module line_echo_checker
    import sle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    input  logic       rx_ready,
    input  logic [7:0] rx_byte,
    input  logic       res_valid,
    input  logic       res_ready,
    input  logic [7:0] out_byte,
    input  logic [1:0] out_kind,
    input  logic       last_of_run,
    output int         fail_count,
    output int         pending
);

    typedef struct {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } echo_beat_t;

    echo_beat_t expected_beats[$];
    logic [7:0] held_text [LINE_CAP];
    int         held_len;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        held_len   = 0;
    end

    function automatic void queue_beat(input logic [7:0] data, input logic [1:0] kind);
        echo_beat_t beat;
        beat.data = data;
        beat.kind = kind;
        beat.last = 1'b0;
        expected_beats.push_back(beat);
    endfunction

    function automatic void edit_line(input logic [7:0] rx);
        int         first;
        int         keep;
        echo_beat_t tail;
        first = expected_beats.size();
        if (rx == CH_CR || rx == CH_LF)
        begin
            if (held_len > 0)
            begin
                queue_beat(CH_CR, KIND_ECHO);
                queue_beat(CH_LF, KIND_ECHO);
                keep = held_len;
                while (keep > 0 && held_text[keep-1] == CH_SPACE)
                    keep--;
                for (int i = 0; i < keep; i++)
                    queue_beat(held_text[i], KIND_LINE);
                queue_beat(8'h00, KIND_END);
                held_len = 0;
            end
        end
        else if (rx == CH_BS || rx == CH_DEL)
        begin
            if (held_len > 0)
            begin
                held_len--;
                queue_beat(CH_BS, KIND_ECHO);
                queue_beat(CH_SPACE, KIND_ECHO);
                queue_beat(CH_BS, KIND_ECHO);
            end
        end
        else if (rx >= CH_PRINT_LO && rx <= CH_PRINT_HI)
        begin
            if (held_len < LINE_CAP - 1)
            begin
                held_text[held_len] = rx;
                held_len++;
                queue_beat(rx, KIND_ECHO);
            end
        end
        if (expected_beats.size() > first)
        begin
            tail      = expected_beats.pop_back();
            tail.last = 1'b1;
            expected_beats.push_back(tail);
        end
    endfunction

    task automatic report_mismatch(input string what, input echo_beat_t want);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected byte %h kind %0d last %0d, got byte %h kind %0d last %0d",
                     $time, what, want.data, want.kind, want.last,
                     out_byte, out_kind, last_of_run);
    endtask

    always @(posedge clk)
    begin
        echo_beat_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    want.data = 8'h00;
                    want.kind = KIND_RSVD;
                    want.last = 1'b0;
                    report_mismatch("unexpected result beat", want);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (out_byte !== want.data || out_kind !== want.kind
                        || last_of_run !== want.last)
                        report_mismatch("result mismatch", want);
                end
            end
            if (rx_valid && rx_ready)
                edit_line(rx_byte);
            pending = expected_beats.size();
        end
    end

endmodule

/* bench/testbench.sv */
// top of the serial line editor bench: clock, reset, byte stimulus with random
// idling and a long receiver hold-off, watchdog and verdict
// depends on sle_pkg, serial_line_editor and line_echo_checker
module testbench;
    import sle_pkg::*;

    localparam int ITEM_GOAL  = 210;
    localparam int HOLD_LEN   = 300;
    localparam int STALL_MAX  = 2000;
    localparam int DRAIN_WAIT = 2 * LINE_CAP + 8;

    logic       clk;
    logic       rst_n;
    logic       rx_valid;
    logic       rx_ready;
    logic [7:0] rx_byte;
    logic       res_valid;
    logic       res_ready;
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       last_of_run;

    int fail_count;
    int pending;
    int sent_count;
    int hold_left;
    bit quiet;
    bit want_hold;

    logic [7:0] opening_bytes[$];

    serial_line_editor uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_byte    (rx_byte),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_byte   (out_byte),
        .out_kind   (out_kind),
        .last_of_run(last_of_run)
    );

    line_echo_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_byte    (rx_byte),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_byte   (out_byte),
        .out_kind   (out_kind),
        .last_of_run(last_of_run),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] text_char();
        if ($urandom_range(3) == 0)
            return CH_SPACE;
        return 8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
    endfunction

    task automatic send_byte(input logic [7:0] value);
        while (!quiet && $urandom_range(99) < 12)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= value;
        do
            @(posedge clk);
        while (!rx_ready);
        sent_count++;
    endtask

    task automatic send_line(input int len, input bit with_erase, input bit terminate);
        for (int i = 0; i < len; i++)
        begin
            if (with_erase && $urandom_range(9) == 0)
                send_byte($urandom_range(1) ? CH_BS : CH_DEL);
            send_byte(text_char());
        end
        if (terminate)
        begin
            case ($urandom_range(3))
                0: send_byte(CH_CR);
                1: send_byte(CH_LF);
                2:
                begin
                    send_byte(CH_CR);
                    send_byte(CH_LF);
                end
                default:
                begin
                    send_byte(CH_LF);
                    send_byte(CH_CR);
                end
            endcase
        end
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial
    begin
        res_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res_ready <= 1'b0;
                hold_left--;
            end
            else if (want_hold)
            begin
                want_hold = 1'b0;
                hold_left = HOLD_LEN - 1;
                res_ready <= 1'b0;
            end
            else
                res_ready <= quiet || $urandom_range(99) >= 12;
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_MAX)
        begin
            @(posedge clk);
            if ((rx_valid && rx_ready) || (res_valid && res_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** serial_line_editor: FAILED **");
        $finish;
    end

    initial
    begin
        int  pick;
        bit  hold_done;
        rst_n      = 1'b0;
        rx_valid   = 1'b0;
        rx_byte    = 8'h00;
        quiet      = 1'b0;
        want_hold  = 1'b0;
        hold_done  = 1'b0;
        sent_count = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // trailing trim, erase, blank lines, empty erase, ignored controls, all-space line
        opening_bytes = '{8'h41, CH_SPACE, CH_PRINT_HI, CH_SPACE, CH_BS, CH_DEL,
                          CH_SPACE, CH_SPACE, CH_CR, CH_LF, CH_BS, CH_DEL, CH_CR,
                          8'h00, 8'h1F, 8'h09, 8'h80, 8'hFF,
                          CH_SPACE, CH_SPACE, CH_LF, 8'h7D, 8'h21, CH_CR};
        foreach (opening_bytes[i])
            send_byte(opening_bytes[i]);
        // overfilled line, extra bytes dropped
        send_line(LINE_CAP + 1, 1'b0, 1'b1);

        while (sent_count < ITEM_GOAL)
        begin
            quiet = sent_count >= 90 && sent_count < 140;
            if (!hold_done && sent_count >= 150)
            begin
                hold_done = 1'b1;
                want_hold = 1'b1;
                send_line(LINE_CAP - 1, 1'b0, 1'b1);
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    send_line(($urandom_range(9) == 0) ?
                              $urandom_range(LINE_CAP + 2, LINE_CAP - 4) :
                              $urandom_range(8), 1'b1, 1'b1);
                else if (pick < 80)
                    send_byte(8'($urandom_range(255)));
                else if (pick < 90)
                    repeat ($urandom_range(4, 1))
                        send_byte($urandom_range(1) ? CH_BS : CH_DEL);
                else
                    send_line($urandom_range(5, 1), 1'b1, 1'b0);
            end
        end
        quiet = 1'b0;
        rx_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("** serial_line_editor: PASSED **");
        else
            $display("** serial_line_editor: FAILED **");
        $finish;
    end

endmodule
